// ===== src/rfp_pkg.sv =====
// Request frame parser package: phase encoding, result codes, field ids
// and the result record shared by the parser, output register and top.
// No dependencies.
`default_nettype none

package rfp_pkg;

  // Parser phases
  typedef enum logic [3:0] {
    PH_PREFIX    = 4'd0,
    PH_VARIANT   = 4'd1,
    PH_ADDR_LEN  = 4'd2,
    PH_ADDR_DATA = 4'd3,
    PH_URI_LEN   = 4'd4,
    PH_URI_DATA  = 4'd5,
    PH_METH_LEN  = 4'd6,
    PH_METH_DATA = 4'd7,
    PH_COUNT     = 4'd8,
    PH_KV_LEN    = 4'd9,
    PH_KV_DATA   = 4'd10,
    PH_BODY_LEN  = 4'd11,
    PH_BODY_DATA = 4'd12,
    PH_DISCARD   = 4'd13
  } rfp_phase_e;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_NUM  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Field ids
  localparam logic [2:0] FID_ADDR  = 3'd0;
  localparam logic [2:0] FID_URI   = 3'd1;
  localparam logic [2:0] FID_METH  = 3'd2;
  localparam logic [2:0] FID_HKEY  = 3'd3;
  localparam logic [2:0] FID_HVAL  = 3'd4;
  localparam logic [2:0] FID_BODY  = 3'd5;
  localparam logic [2:0] FID_COUNT = 3'd6;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_TRUNC    = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_VARIANT  = 3'd3;
  localparam logic [2:0] ERR_EXCEEDS  = 3'd4;

  // LEB128 bits
  localparam logic [7:0] CONT_BIT   = 8'h80;
  localparam logic [7:0] GROUP_MASK = 8'h7f;
  localparam logic [3:0] MAX_GROUPS = 4'd9;

  // One result item
  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic [2:0]  field_id;
    logic [63:0] value;
    logic        field_last;
    logic        frame_last;
    logic [2:0]  error_code;
  } rfp_res_t;

  // Field that a length or data phase belongs to
  function automatic logic [2:0] len_field(rfp_phase_e ph, logic is_value);
    logic [2:0] fid;
    case (ph)
      PH_ADDR_LEN, PH_ADDR_DATA: fid = FID_ADDR;
      PH_URI_LEN, PH_URI_DATA:   fid = FID_URI;
      PH_METH_LEN, PH_METH_DATA: fid = FID_METH;
      PH_KV_LEN, PH_KV_DATA:     fid = is_value ? FID_HVAL : FID_HKEY;
      default:                   fid = FID_BODY;
    endcase
    return fid;
  endfunction

  // Data phase that follows a nonzero length
  function automatic rfp_phase_e data_phase(logic [2:0] fid);
    rfp_phase_e ph;
    case (fid)
      FID_ADDR:           ph = PH_ADDR_DATA;
      FID_URI:            ph = PH_URI_DATA;
      FID_METH:           ph = PH_METH_DATA;
      FID_HKEY, FID_HVAL: ph = PH_KV_DATA;
      default:            ph = PH_BODY_DATA;
    endcase
    return ph;
  endfunction

endpackage

`default_nettype wire

// ===== src/request_frame_parser.sv =====
// Request frame parser top: input byte register, parser core, result register.
// A byte accepted into the input register shows its result, if any, in the result register
// once that register is free; a held result delays it until taken.
// Throughput: one byte per cycle unless a held result stalls the step; the parser step
// is combinational and the input register lets a new byte in while a result waits.
// Reset: asynchronous, clears both registers' valid flags and all parser state.
`default_nettype none

module request_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [63:0] value, [66:64] error_code, rest 0
  output logic [5:0]       m_axis_tuser,   // [1:0] kind, [4:2] field_id, [5] field_last
  output logic             m_axis_tlast    // frame_last
);
  import rfp_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       fire;
  logic       out_space;
  rfp_res_t   step_res;
  rfp_res_t   out_res;

  assign fire          = in_vld_q && out_space;
  assign s_axis_tready = !in_vld_q || fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  rfp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (fire),
    .in_byte_i (in_byte_q),
    .res_o     (step_res)
  );

  rfp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && step_res.vld),
    .res_i   (step_res),
    .take_i  (m_axis_tready),
    .space_o (out_space),
    .vld_o   (m_axis_tvalid),
    .res_o   (out_res)
  );

  // Output packing
  assign m_axis_tdata = {5'd0, out_res.error_code, out_res.value};
  assign m_axis_tuser = {out_res.field_last, out_res.field_id, out_res.kind};
  assign m_axis_tlast = out_res.frame_last;

  // An error result always closes its frame
  a_err_closes_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res.kind == KIND_ERR |-> out_res.frame_last)
    else $error("error result without frame_last");

  // Error code is set exactly on error results
  a_err_code_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_res.kind == KIND_ERR) == (out_res.error_code != ERR_NONE)))
    else $error("error_code disagrees with kind");

  // A stepped byte that yields a result shows it on the next cycle
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && step_res.vld |=> m_axis_tvalid)
    else $error("result lost in output register");

  // A byte held in the input register is stepped whenever the output has room
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && (!m_axis_tvalid || m_axis_tready) |-> fire)
    else $error("parser stalled with free output");

endmodule

`default_nettype wire

// ===== src/rfp_parser.sv =====
// Parser core: frame/field state registers and the one-byte step logic.
// Depends on rfp_pkg.
`default_nettype none

module rfp_parser (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,   // consume in_byte_i this cycle
  input  wire logic [7:0]      in_byte_i,
  output rfp_pkg::rfp_res_t    res_o     // result of this step, vld may be 0
);
  import rfp_pkg::*;

  rfp_phase_e  phase_q, phase_d;
  logic [1:0]  prefix_cnt_q, prefix_cnt_d;
  logic [31:0] frame_left_q, frame_left_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  grp_q, grp_d;
  logic [31:0] field_left_q, field_left_d;
  logic [63:0] headers_q, headers_d;
  logic        is_value_q, is_value_d;

  logic [31:0] fl_dec;
  logic [31:0] fld_dec;
  logic [63:0] hdr_dec;
  logic [31:0] pre_frame;
  logic [6:0]  shift_full;
  logic [5:0]  sh;
  logic [63:0] v;

  logic        do_fail;
  logic [2:0]  fail_code;
  logic [31:0] fail_left;
  logic        do_fin;
  logic [1:0]  fin_kind;
  logic [2:0]  fin_fid;
  logic [63:0] fin_val;
  logic        fin_done;
  logic [2:0]  cur_fid;

  assign fl_dec     = frame_left_q - 32'd1;
  assign fld_dec    = field_left_q - 32'd1;
  assign hdr_dec    = headers_q - 64'd1;
  assign shift_full = 7'(grp_q) * 7'd7;
  assign sh         = shift_full[5:0];
  assign v          = acc_q | ({56'd0, in_byte_i} << sh);
  assign cur_fid    = len_field(phase_q, is_value_q);

  // Length prefix assembly, little-endian
  always_comb begin
    case (prefix_cnt_q)
      2'd0:    pre_frame = {24'd0, in_byte_i};
      2'd1:    pre_frame = frame_left_q | {16'd0, in_byte_i, 8'd0};
      2'd2:    pre_frame = frame_left_q | {8'd0, in_byte_i, 16'd0};
      default: pre_frame = frame_left_q | {in_byte_i, 24'd0};
    endcase
  end

  // One byte step
  always_comb begin
    phase_d      = phase_q;
    prefix_cnt_d = prefix_cnt_q;
    frame_left_d = frame_left_q;
    acc_d        = acc_q;
    grp_d        = grp_q;
    field_left_d = field_left_q;
    headers_d    = headers_q;
    is_value_d   = is_value_q;
    res_o        = '0;
    do_fail      = 1'b0;
    fail_code    = ERR_NONE;
    fail_left    = fl_dec;
    do_fin       = 1'b0;
    fin_kind     = KIND_BYTE;
    fin_fid      = FID_ADDR;
    fin_val      = '0;
    fin_done     = 1'b0;

    case (phase_q)
      PH_PREFIX: begin
        frame_left_d = pre_frame;
        prefix_cnt_d = prefix_cnt_q + 2'd1;
        fail_left    = pre_frame;
        if (prefix_cnt_q == 2'd3) begin
          acc_d      = '0;
          grp_d      = '0;
          is_value_d = 1'b0;
          if (pre_frame == 32'd0) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNC;
          end else begin
            phase_d = PH_VARIANT;
          end
        end
      end

      PH_DISCARD: begin
        frame_left_d = fl_dec;
        if (fl_dec == 32'd0) phase_d = PH_PREFIX;
      end

      // Payload bytes
      PH_ADDR_DATA, PH_URI_DATA, PH_METH_DATA, PH_KV_DATA, PH_BODY_DATA: begin
        frame_left_d = fl_dec;
        field_left_d = fld_dec;
        if (fld_dec != 32'd0) begin
          res_o.vld      = 1'b1;
          res_o.kind     = KIND_BYTE;
          res_o.field_id = cur_fid;
          res_o.value    = {56'd0, in_byte_i};
        end else begin
          do_fin   = 1'b1;
          fin_kind = KIND_BYTE;
          fin_fid  = cur_fid;
          fin_val  = {56'd0, in_byte_i};
        end
      end

      // LEB128 bytes
      PH_VARIANT, PH_ADDR_LEN, PH_URI_LEN, PH_METH_LEN, PH_COUNT,
      PH_KV_LEN, PH_BODY_LEN: begin
        frame_left_d = fl_dec;
        if ((in_byte_i & CONT_BIT) != 8'd0) begin
          if (grp_q <= MAX_GROUPS)
            acc_d = acc_q | ({56'd0, in_byte_i & GROUP_MASK} << sh);
          if (grp_q <= MAX_GROUPS) grp_d = grp_q + 4'd1;
          if (fl_dec == 32'd0) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNC;
          end
        end else if (grp_q > MAX_GROUPS || (grp_q == MAX_GROUPS && in_byte_i > 8'd1)) begin
          do_fail   = 1'b1;
          fail_code = ERR_OVERFLOW;
        end else begin
          acc_d = '0;
          grp_d = '0;
          if (phase_q == PH_VARIANT) begin
            if (v != 64'd0) begin
              do_fail   = 1'b1;
              fail_code = ERR_VARIANT;
            end else if (fl_dec == 32'd0) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNC;
            end else begin
              phase_d = PH_ADDR_LEN;
            end
          end else if (phase_q == PH_COUNT) begin
            if (fl_dec == 32'd0) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNC;
            end else begin
              headers_d        = v;
              is_value_d       = 1'b0;
              phase_d          = (v != 64'd0) ? PH_KV_LEN : PH_BODY_LEN;
              res_o.vld        = 1'b1;
              res_o.kind       = KIND_NUM;
              res_o.field_id   = FID_COUNT;
              res_o.value      = v;
              res_o.field_last = 1'b1;
            end
          end else if (v > {32'd0, fl_dec}) begin
            do_fail   = 1'b1;
            fail_code = ERR_EXCEEDS;
          end else if (v == 64'd0) begin
            do_fin   = 1'b1;
            fin_kind = KIND_NUM;
            fin_fid  = cur_fid;
            fin_val  = '0;
          end else begin
            field_left_d   = v[31:0];
            phase_d        = data_phase(cur_fid);
            res_o.vld      = 1'b1;
            res_o.kind     = KIND_NUM;
            res_o.field_id = cur_fid;
            res_o.value    = v;
          end
        end
      end

      default: phase_d = PH_PREFIX;
    endcase

    // Close a finished field
    if (do_fin) begin
      case (fin_fid)
        FID_ADDR: phase_d = PH_URI_LEN;
        FID_URI:  phase_d = PH_METH_LEN;
        FID_METH: phase_d = PH_COUNT;
        FID_HKEY: begin
          is_value_d = 1'b1;
          phase_d    = PH_KV_LEN;
        end
        FID_HVAL: begin
          headers_d  = hdr_dec;
          is_value_d = 1'b0;
          phase_d    = (hdr_dec != 64'd0) ? PH_KV_LEN : PH_BODY_LEN;
        end
        default: begin
          phase_d  = (fl_dec != 32'd0) ? PH_DISCARD : PH_PREFIX;
          fin_done = 1'b1;
        end
      endcase
      if (!fin_done && fl_dec == 32'd0) begin
        do_fail   = 1'b1;
        fail_code = ERR_TRUNC;
      end else begin
        res_o.vld        = 1'b1;
        res_o.kind       = fin_kind;
        res_o.field_id   = fin_fid;
        res_o.value      = fin_val;
        res_o.field_last = 1'b1;
        res_o.frame_last = fin_done;
      end
    end

    // Error: drop the rest of the frame
    if (do_fail) begin
      acc_d   = '0;
      grp_d   = '0;
      phase_d = (fail_left != 32'd0) ? PH_DISCARD : PH_PREFIX;
      res_o            = '0;
      res_o.vld        = 1'b1;
      res_o.kind       = KIND_ERR;
      res_o.frame_last = 1'b1;
      res_o.error_code = fail_code;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_PREFIX;
      prefix_cnt_q <= '0;
      frame_left_q <= '0;
      acc_q        <= '0;
      grp_q        <= '0;
      field_left_q <= '0;
      headers_q    <= '0;
      is_value_q   <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      prefix_cnt_q <= prefix_cnt_d;
      frame_left_q <= frame_left_d;
      acc_q        <= acc_d;
      grp_q        <= grp_d;
      field_left_q <= field_left_d;
      headers_q    <= headers_d;
      is_value_q   <= is_value_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/rfp_out_reg.sv =====
// Result register: holds one result item until the downstream side takes it.
// Depends on rfp_pkg.
`default_nettype none

module rfp_out_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,   // new result this cycle
  input  wire rfp_pkg::rfp_res_t res_i,
  input  wire logic          take_i,   // downstream ready
  output logic               space_o,  // can load this cycle
  output logic               vld_o,
  output rfp_pkg::rfp_res_t  res_o
);
  import rfp_pkg::*;

  logic     vld_q;
  rfp_res_t res_q;

  assign space_o = !vld_q || take_i;
  assign vld_o   = vld_q;
  assign res_o   = res_q;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= 1'b1;
    end else if (take_i) begin
      vld_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire
